[rtl/rrot_pkg.sv]
package rrot_pkg;

  localparam int OPCODE_W = 2;
  localparam int FIELD_W  = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_RESERVE = 2'd0,
    OP_CHECK   = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_RANGE = 2'd2,
    ST_OVERLAP   = 2'd3
  } status_t;

  // compare unit control: clr starts a new scan, en marks a valid entry word
  typedef struct packed {
    logic clr;
    logic en;
  } cmp_ctl_t;

endpackage

[rtl/rrot_if.sv]
interface rrot_in_if import rrot_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [FIELD_W-1:0]  range_start;
  logic [FIELD_W-1:0]  range_end;

  modport source (output valid, output opcode, output range_start, output range_end,
                  input ready);
  modport sink   (input valid, input opcode, input range_start, input range_end,
                  output ready);
endinterface

interface rrot_out_if import rrot_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                overlaps;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output overlaps, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input overlaps, input entry_count,
                  output ready);
endinterface

[rtl/rrot_range_ram.sv]
module rrot_range_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 64
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [AW-1:0]                             wr_lo,
  input  logic [AW-1:0]                             wr_hi,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [AW-1:0]                             rd_lo,
  output logic [AW-1:0]                             rd_hi
);

  logic [AW-1:0] mem_lo [DEPTH];
  logic [AW-1:0] mem_hi [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_lo[wr_addr] <= wr_lo;
      mem_hi[wr_addr] <= wr_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lo <= mem_lo[rd_addr];
      rd_hi <= mem_hi[rd_addr];
    end
  end

endmodule

[rtl/rrot_cmp.sv]
module rrot_cmp import rrot_pkg::*; #(
  parameter int AW = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cmp_ctl_t      ctl,
  input  logic [AW-1:0] q_lo,
  input  logic [AW-1:0] q_hi,
  input  logic [AW-1:0] e_lo,
  input  logic [AW-1:0] e_hi,
  output logic          hit_r
);

  logic hit_nxt;

  // half-open ranges overlap when each start lies below the other end
  always_comb begin
    hit_nxt = hit_r;
    if (ctl.clr) begin
      hit_nxt = 1'b0;
    end else if (ctl.en && (q_lo < e_hi) && (e_lo < q_hi)) begin
      hit_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

endmodule

[rtl/reserved_range_overlap_table.sv]
// reserved address range table
// in_ch carries one command word: opcode (reserve, check, clear), range_start and
// range_end of a half-open range; addresses are cut to ADDR_WIDTH bits.
// out_ch returns exactly one result word per command: status, overlaps flag and
// the entry count after the command.
// a reserve or check reads the stored ranges from a RAM with separate read and
// write ports, one entry a cycle, and compares each against the query; this scan
// sets the rate. reserve and check pass from accept through the scan step to the
// response step; clear, an unused opcode and a reserve refused by the full or bad
// range test go from accept straight to the response step.
// in_ch is ready only while no command is in flight; one command at a time, the
// next word is taken the cycle after a result is loaded.
// the result sits in an output register, so a new command is taken while an old
// result still waits; a stalled out_ch holds the result and the table update.
// reset empties the table (count to zero) and drops any pending result; the RAM
// contents are not cleared and need no sweep, entries past the count are never read.
module reserved_range_overlap_table import rrot_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int ADDR_WIDTH  = 64
) (
  input logic       clk,
  input logic       rst_n,
  rrot_in_if.sink   in_ch,
  rrot_out_if.source out_ch
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  state_t                state_r;
  opcode_t               op_r;
  status_t               status_r;    // status decided at accept (full or bad range)
  logic [ADDR_WIDTH-1:0] lo_r;
  logic [ADDR_WIDTH-1:0] hi_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      issue_r;     // next entry to read
  logic                  pend_r;      // read data for an entry arrives this cycle

  logic                  out_valid_r;
  status_t               out_status_r;
  logic                  out_overlaps_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic                  accept;
  logic                  full;
  logic [ADDR_WIDTH-1:0] in_lo;
  logic [ADDR_WIDTH-1:0] in_hi;
  opcode_t               in_op;
  logic                  rd_en;
  logic                  wr_en;
  logic                  resp_go;
  logic                  scan_done;
  logic                  hit_r;
  logic                  do_write;
  logic [ADDR_WIDTH-1:0] rd_lo;
  logic [ADDR_WIDTH-1:0] rd_hi;
  cmp_ctl_t              cmp_ctl;
  logic [CNT_W-1:0]      count_nxt;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_lo       = in_ch.range_start[ADDR_WIDTH-1:0];
  assign in_hi       = in_ch.range_end[ADDR_WIDTH-1:0];
  assign in_op       = opcode_t'(in_ch.opcode);
  assign full        = (count_r == CNT_W'(TABLE_DEPTH));

  // one read per cycle over the valid entries
  assign rd_en     = (state_r == S_SCAN) && (issue_r != count_r);
  assign scan_done = (state_r == S_SCAN) && (issue_r == count_r) && !pend_r;

  // result goes out when the output register is free
  assign resp_go  = (state_r == S_RESP) && (!out_valid_r || out_ch.ready);
  // a reserve that passed the early tests and hit nothing is appended
  assign do_write = (op_r == OP_RESERVE) && (status_r == ST_OK) && !hit_r;
  assign wr_en    = resp_go && do_write;

  assign cmp_ctl.clr = accept;
  assign cmp_ctl.en  = pend_r;

  always_comb begin
    count_nxt = count_r;
    if (op_r == OP_CLEAR) begin
      count_nxt = '0;
    end else if (do_write) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // entry_count keeps the low bits only
  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  // reads happen only in the scan and the write only in the response step, so the
  // RAM never sees a read and a write to the same entry in one cycle
  rrot_range_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (ADDR_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_lo   (lo_r),
    .wr_hi   (hi_r),
    .rd_en   (rd_en),
    .rd_addr (issue_r[IDX_W-1:0]),
    .rd_lo   (rd_lo),
    .rd_hi   (rd_hi)
  );

  rrot_cmp #(
    .AW (ADDR_WIDTH)
  ) u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cmp_ctl),
    .q_lo  (lo_r),
    .q_hi  (hi_r),
    .e_lo  (rd_lo),
    .e_hi  (rd_hi),
    .hit_r (hit_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= OP_NONE;
      status_r    <= ST_OK;
    end else begin
      pend_r <= rd_en;
      if (rd_en) begin
        issue_r <= issue_r + CNT_W'(1);
      end
      // a result loaded in the same cycle keeps the output word valid
      if (out_valid_r && out_ch.ready && !resp_go) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r     <= in_op;
            lo_r     <= in_lo;
            hi_r     <= in_hi;
            issue_r  <= '0;
            priority if (in_op == OP_RESERVE && full) begin
              status_r <= ST_FULL;
              state_r  <= S_RESP;
            end else if (in_op == OP_RESERVE && !(in_lo < in_hi)) begin
              status_r <= ST_BAD_RANGE;
              state_r  <= S_RESP;
            end else if (in_op == OP_RESERVE || in_op == OP_CHECK) begin
              status_r <= ST_OK;
              state_r  <= S_SCAN;
            end else begin
              status_r <= ST_OK;
              state_r  <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (resp_go) begin
            out_valid_r <= 1'b1;
            out_count_r <= count_ext[COUNT_W-1:0];
            count_r     <= count_nxt;
            state_r     <= S_IDLE;
            if (op_r == OP_RESERVE && status_r == ST_OK && hit_r) begin
              out_status_r <= ST_OVERLAP;
            end else begin
              out_status_r <= status_r;
            end
            out_overlaps_r <= hit_r && (op_r == OP_CHECK ||
                                        (op_r == OP_RESERVE && status_r == ST_OK));
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.overlaps    = out_overlaps_r;
  assign out_ch.entry_count = out_count_r;

  // the table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // an append only happens for a reserve into a table with room
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (op_r == OP_RESERVE) && !full)
    else $error("table write without room");

  // the RAM port is never asked to read and write together
  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("read and write in the same cycle");

  // reads never run past the valid entries
  a_read_valid: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (issue_r < count_r))
    else $error("read of an entry past the count");

  // a new result word is only loaded from the response step
  a_load_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result loaded outside the response step");

endmodule

[dv/range_table_checker.sv]
module range_table_checker import rrot_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int ADDR_WIDTH  = 64
) (
  input  logic clk,
  input  logic rst_n,
  rrot_in_if   cmd_mon,
  rrot_out_if  res_mon,
  output int   fail_count,
  output int   pending,
  output int   replies_checked,
  output int   full_refusals,
  output int   overlap_refusals
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [FIELD_W-1:0] addr_t;

  typedef struct packed {
    status_t            status;
    logic               overlaps;
    logic [COUNT_W-1:0] entry_count;
  } table_reply_t;

  // wraps to all ones when ADDR_WIDTH equals the field width
  localparam addr_t ADDR_MASK = (addr_t'(1) << ADDR_WIDTH) - addr_t'(1);

  addr_t        span_lo [TABLE_DEPTH];
  addr_t        span_hi [TABLE_DEPTH];
  int unsigned  held;
  table_reply_t owed_replies [$];

  function automatic logic hits_reserved(addr_t lo, addr_t hi);
    for (int i = 0; i < held; i++) begin
      if (lo < span_hi[i] && span_lo[i] < hi) return 1'b1;
    end
    return 1'b0;
  endfunction

  // applies one command to the shadow table and returns the reply it owes
  function automatic table_reply_t predict_table_reply(opcode_t op, addr_t start_in,
                                                       addr_t end_in);
    addr_t        lo;
    addr_t        hi;
    table_reply_t r;
    lo = start_in & ADDR_MASK;
    hi = end_in & ADDR_MASK;
    r.status   = ST_OK;
    r.overlaps = 1'b0;
    case (op)
      OP_RESERVE: begin
        if (held >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (lo >= hi) begin
          r.status = ST_BAD_RANGE;
        end else if (hits_reserved(lo, hi)) begin
          r.status   = ST_OVERLAP;
          r.overlaps = 1'b1;
        end else begin
          span_lo[held] = lo;
          span_hi[held] = hi;
          held++;
        end
      end
      OP_CHECK: r.overlaps = hits_reserved(lo, hi);
      OP_CLEAR: held = 0;
      default: ;
    endcase
    r.entry_count = COUNT_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      owed_replies.delete();
      held = 0;
    end else begin
      // drain first so a stray result word cannot consume a fresh expectation
      if (res_mon.valid && res_mon.ready) begin
        if (owed_replies.size() == 0) begin
          $display("%0t: result word with nothing owed, actual status %0d overlaps %0b count %0d",
                   $time, res_mon.status, res_mon.overlaps, res_mon.entry_count);
          fail_count++;
        end else begin
          want = owed_replies.pop_front();
          replies_checked++;
          if (res_mon.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     res_mon.status);
            fail_count++;
          end
          if (res_mon.overlaps !== want.overlaps) begin
            $display("%0t: overlaps expected %0b actual %0b", $time, want.overlaps,
                     res_mon.overlaps);
            fail_count++;
          end
          if (res_mon.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                     res_mon.entry_count);
            fail_count++;
          end
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        want = predict_table_reply(opcode_t'(cmd_mon.opcode), cmd_mon.range_start,
                                   cmd_mon.range_end);
        if (want.status == ST_FULL) full_refusals++;
        if (want.status == ST_OVERLAP) overlap_refusals++;
        owed_replies.push_back(want);
      end
    end
    pending = owed_replies.size();
  end

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrot_pkg::*;

  localparam int TABLE_DEPTH      = 64;
  localparam int ADDR_WIDTH       = 64;
  localparam int WORD_GOAL        = 1400;
  localparam int LONG_HOLD_CYCLES = 600;

  typedef logic [FIELD_W-1:0] addr_t;

  localparam addr_t ADDR_TOP = '1;

  // receiver behaviors, picked per stretch
  typedef enum int {
    RX_OPEN,      // ready held high, no stalls at all
    RX_COIN,      // ready on a fair coin each cycle
    RX_PERIODIC,  // ready at a regular period picked per stretch
    RX_SPARSE     // ready rarely
  } stall_mode_t;

  // kinds of random command sequences
  typedef enum int {
    EP_CLUSTER,   // reserves and checks packed into a small window, lots of overlaps
    EP_FILL,      // fill all entries with disjoint spans, then push past full
    EP_NOISE,     // any opcode, any address
    EP_PROBE      // checks and a few reserves against whatever the table holds
  } episode_t;

  logic  clk;
  logic  rst_n;

  int    fail_count;
  int    pending;
  int    replies_checked;
  int    full_refusals;
  int    overlap_refusals;

  int    words_sent;
  int    op_tally [4];
  int    burst_left;
  int    hold_asks;
  int    hold_done;
  addr_t work_base;

  rrot_in_if  in_ch ();
  rrot_out_if out_ch ();

  reserved_range_overlap_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  range_table_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_mon          (in_ch),
    .res_mon          (out_ch),
    .fail_count       (fail_count),
    .pending          (pending),
    .replies_checked  (replies_checked),
    .full_refusals    (full_refusals),
    .overlap_refusals (overlap_refusals)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #12_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic addr_t rand_addr();
    return {$urandom, $urandom};
  endfunction

  // window base: bottom of the space, just under the top, or anywhere
  function automatic addr_t pick_base();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return ADDR_TOP - addr_t'($urandom_range(0, 8191));
      default: return rand_addr();
    endcase
  endfunction

  // offers one command word and returns once it is taken; bursts of random
  // length, random gaps in between, zero-length gaps for back-to-back stretches
  task automatic send_word(opcode_t op, addr_t lo, addr_t hi);
    int gap;
    @(negedge clk);
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid       = 1'b1;
    in_ch.opcode      = op;
    in_ch.range_start = lo;
    in_ch.range_end   = hi;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    burst_left--;
    words_sent++;
    op_tally[int'(op)]++;
  endtask

  // receiver: its own stall pattern, plus long hold-offs when asked for
  initial begin
    stall_mode_t mode;
    int          span;
    int          period;
    int          tick;
    out_ch.ready = 1'b0;
    tick = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_done < hold_asks) begin
        // long hold-off: the output register fills and the block stops taking words
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_done++;
      end else begin
        mode   = stall_mode_t'($urandom_range(0, 3));
        span   = $urandom_range(8, 120);
        period = $urandom_range(2, 6);
        repeat (span) begin
          @(negedge clk);
          tick++;
          case (mode)
            RX_OPEN:     out_ch.ready = 1'b1;
            RX_COIN:     out_ch.ready = ($urandom_range(0, 1) == 1);
            RX_PERIODIC: out_ch.ready = (tick % period == 0);
            default:     out_ch.ready = ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  // stimulus
  initial begin
    episode_t ep;
    addr_t    lo;
    addr_t    hi;
    int       roll;
    int       n;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_NONE;
    in_ch.range_start = '0;
    in_ch.range_end   = '0;
    burst_left        = 0;
    hold_asks         = 0;
    hold_done         = 0;
    work_base         = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every opcode, touching and reversed spans
    send_word(OP_CHECK,   '0,          ADDR_TOP);    // empty table never hits
    send_word(OP_RESERVE, 64'h5,       64'h5);       // empty span refused
    send_word(OP_RESERVE, 64'h10,      64'h5);       // reversed span refused
    send_word(OP_RESERVE, 64'h100,     64'h200);
    send_word(OP_RESERVE, 64'h200,     64'h300);     // touching is not overlap
    send_word(OP_RESERVE, 64'h1ff,     64'h201);     // straddles both
    send_word(OP_RESERVE, 64'h300,     64'h200);     // bad span beats overlap
    send_word(OP_CHECK,   64'h300,     64'h400);     // just past the end
    send_word(OP_CHECK,   64'h2ff,     64'h300);     // last address
    send_word(OP_CHECK,   64'h300,     64'h100);     // reversed check, misses
    send_word(OP_CHECK,   64'h150,     64'h120);     // reversed check, still hits
    send_word(OP_CHECK,   64'h150,     64'h150);     // empty check inside a span hits
    send_word(OP_NONE,    ADDR_TOP,    ADDR_TOP);    // unused opcode, no effect
    send_word(OP_RESERVE, ADDR_TOP - 1, ADDR_TOP);   // top of the space
    send_word(OP_RESERVE, '0,          ADDR_TOP);    // overlaps everything
    send_word(OP_CHECK,   ADDR_TOP,    ADDR_TOP);    // empty at the very top
    send_word(OP_CLEAR,   ADDR_TOP,    '0);
    send_word(OP_CHECK,   64'h100,     64'h200);     // gone after clear
    send_word(OP_RESERVE, '0,          ADDR_TOP);    // nearly whole space
    send_word(OP_CHECK,   '0,          64'h1);
    send_word(OP_RESERVE, ADDR_TOP,    '0);          // maximal reversal
    send_word(OP_NONE,    '0,          '0);
    send_word(OP_CLEAR,   '0,          '0);

    // random sequences
    while (words_sent < WORD_GOAL) begin
      // two long receiver hold-offs, one early and one halfway, while words keep coming
      if (hold_asks < 2 && words_sent > hold_asks * (WORD_GOAL / 2)) hold_asks++;

      roll = $urandom_range(0, 9);
      if (roll < 4)      ep = EP_CLUSTER;
      else if (roll < 6) ep = EP_FILL;
      else if (roll < 7) ep = EP_NOISE;
      else               ep = EP_PROBE;

      case (ep)
        EP_CLUSTER: begin
          if ($urandom_range(0, 4) != 0) send_word(OP_CLEAR, rand_addr(), rand_addr());
          work_base = pick_base();
          n = $urandom_range(10, 60);
          repeat (n) begin
            lo   = work_base + addr_t'($urandom_range(0, 2047));
            hi   = lo + addr_t'($urandom_range(1, 48));
            roll = $urandom_range(0, 19);
            if (roll < 11) begin
              send_word(OP_RESERVE, lo, hi);
            end else if (roll < 18) begin
              send_word(OP_CHECK, lo, hi);
            end else if (roll < 19) begin
              // empty or reversed, as either a reserve or a check
              hi = lo - addr_t'($urandom_range(0, 8));
              send_word($urandom_range(0, 1) ? OP_RESERVE : OP_CHECK, lo, hi);
            end else begin
              send_word(OP_NONE, lo, hi);
            end
          end
        end

        EP_FILL: begin
          send_word(OP_CLEAR, rand_addr(), rand_addr());
          work_base = pick_base();
          // disjoint spans, one per 64-address slot
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            lo = work_base + addr_t'(i * 64);
            send_word(OP_RESERVE, lo, lo + addr_t'($urandom_range(1, 64)));
          end
          // table should be full now: every reserve is refused, checks still work
          repeat ($urandom_range(4, 12)) begin
            lo = work_base + addr_t'($urandom_range(0, TABLE_DEPTH * 64 + 256));
            if ($urandom_range(0, 3) == 0) hi = lo - addr_t'($urandom_range(0, 4));
            else                           hi = lo + addr_t'($urandom_range(1, 80));
            send_word($urandom_range(0, 1) ? OP_RESERVE : OP_CHECK, lo, hi);
          end
        end

        EP_NOISE: begin
          repeat ($urandom_range(5, 20)) begin
            send_word(opcode_t'($urandom_range(0, 3)), rand_addr(), rand_addr());
          end
        end

        default: begin
          repeat ($urandom_range(10, 40)) begin
            lo = work_base + addr_t'($urandom_range(0, 4095));
            hi = lo + addr_t'($urandom_range(0, 64));
            send_word(($urandom_range(0, 4) == 0) ? OP_RESERVE : OP_CHECK, lo, hi);
          end
        end
      endcase
    end

    @(negedge clk);
    in_ch.valid = 1'b0;

    // let the last results drain, then allow one full scan for anything stray
    wait (pending == 0);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("covered %0d command words: %0d reserve, %0d check, %0d clear, %0d unused opcode",
             words_sent, op_tally[OP_RESERVE], op_tally[OP_CHECK], op_tally[OP_CLEAR],
             op_tally[OP_NONE]);
    $display("%0d results compared, %0d full-table and %0d overlap refusals, %0d long hold-offs",
             replies_checked, full_refusals, overlap_refusals, hold_done);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
